>>> hdl/imm_pkg.sv
// Shared constants and types for the integer matrix multiply core.
package imm_pkg;

  localparam int MAX_DIM_DEF = 64;
  localparam int DIM_W       = 7;
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_PRODUCT = 2'd1;
  localparam logic [1:0] KIND_TRACE   = 2'd2;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } issue_ctl_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } dot_res_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

>>> hdl/imm_if.sv
// Valid/ready channel interfaces for request and result beats.
interface imm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         row;
  logic [5:0]         col;
  logic signed [31:0] a_value;
  logic signed [31:0] b_value;

  modport source (output valid, kind, row, col, a_value, b_value, input ready);
  modport sink   (input valid, kind, row, col, a_value, b_value, output ready);
endinterface

interface imm_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic               is_trace;
  logic               index_error;

  modport source (output valid, result_value, is_trace, index_error, input ready);
  modport sink   (input valid, result_value, is_trace, index_error, output ready);
endinterface

>>> hdl/integer_matrix_multiply_core.sv
// Top level of the integer matrix multiply core.
// A load beat writes one element of A and one of B, and the core is ready again at once.
// A product read and a trace read pass their terms through the one multiply-accumulate
// unit, fed by one read port on each matrix store, which handles one term per cycle, until
// the result stands in the output register. The input is not ready during a read. The
// dimension in use is clamped to MAX_DIM; the stores are not cleared at reset.
module integer_matrix_multiply_core #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [imm_pkg::DIM_W-1:0] cfg_wr_data,
  imm_in_if.sink                    in_beat,
  imm_out_if.source                 out_beat
);
  import imm_pkg::*;

  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0]  dim_r;
  logic [CNT_W-1:0]  eff_dim;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  issue_ctl_t        ctl;
  dot_res_t          dot;
  logic [63:0]       out_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_wr_en) begin
      dim_r <= cfg_wr_data;
    end
  end

  assign eff_dim = (32'(dim_r) > 32'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(dim_r);

  imm_seq #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .eff_dim         (eff_dim),
    .in_valid        (in_beat.valid),
    .in_ready        (in_beat.ready),
    .in_kind         (in_beat.kind),
    .in_row          (in_beat.row),
    .in_col          (in_beat.col),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .ctl             (ctl),
    .a_addr          (a_addr),
    .b_addr          (b_addr),
    .dot             (dot),
    .out_valid       (out_beat.valid),
    .out_ready       (out_beat.ready),
    .out_result      (out_result),
    .out_is_trace    (out_beat.is_trace),
    .out_index_error (out_beat.index_error)
  );

  imm_mac #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_a    (32'(in_beat.a_value)),
    .wr_b    (32'(in_beat.b_value)),
    .ctl     (ctl),
    .a_addr  (a_addr),
    .b_addr  (b_addr),
    .dot     (dot)
  );

  assign out_beat.result_value = $signed(out_result);

`ifndef SYNTHESIS
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat.valid && in_beat.ready &&
    ((in_beat.kind == KIND_PRODUCT) || (in_beat.kind == KIND_TRACE)) |=> !in_beat.ready)
    else $error("core ready in the cycle after a read beat");

  a_dot_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dot.done |-> !in_beat.ready)
    else $error("dot product finished while the sequencer was idle");

  a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.issue |-> !in_beat.ready && !wr_en)
    else $error("store read issued while idle or during a load");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat.valid && out_beat.index_error |->
    (out_beat.result_value == 64'sd0) && !out_beat.is_trace)
    else $error("index error beat carries a value or trace flag");
`endif

endmodule

>>> hdl/imm_mac.sv
// Matrix stores and the shared pipelined multiply-accumulate unit.
module imm_mac #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
  parameter int ADDR_W  = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [31:0]         wr_a,
  input  logic [31:0]         wr_b,
  input  imm_pkg::issue_ctl_t ctl,
  input  logic [ADDR_W-1:0]   a_addr,
  input  logic [ADDR_W-1:0]   b_addr,
  output imm_pkg::dot_res_t   dot
);
  import imm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [31:0] mem_a [0:DEPTH-1];
  logic [31:0] mem_b [0:DEPTH-1];

  logic [31:0] a_q_r;
  logic [31:0] b_q_r;
  logic [31:0] prod_r;
  logic [31:0] acc_r;
  logic        done_r;
  issue_ctl_t  ctl1_r;
  issue_ctl_t  ctl2_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
    if (ctl.issue) begin
      a_q_r <= mem_a[a_addr];
      b_q_r <= mem_b[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      done_r <= ctl2_r.issue && ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_q_r * b_q_r;
    if (ctl2_r.issue) begin
      acc_r <= ctl2_r.first ? prod_r : acc_r + prod_r;
    end
  end

  assign dot.done  = done_r;
  assign dot.value = acc_r;

endmodule

>>> hdl/imm_seq.sv
// Sequencer that walks rows and columns through the multiply-accumulate unit.
module imm_seq #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
  parameter int ADDR_W  = 12,
  parameter int IDX_W   = 6,
  parameter int CNT_W   = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CNT_W-1:0]    eff_dim,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [5:0]          in_row,
  input  logic [5:0]          in_col,
  output logic                wr_en,
  output logic [ADDR_W-1:0]   wr_addr,
  output imm_pkg::issue_ctl_t ctl,
  output logic [ADDR_W-1:0]   a_addr,
  output logic [ADDR_W-1:0]   b_addr,
  input  imm_pkg::dot_res_t   dot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_result,
  output logic                out_is_trace,
  output logic                out_index_error
);
  import imm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  row_r;
  logic [IDX_W-1:0]  col_r;
  logic [IDX_W-1:0]  k_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  dot_cnt_r;
  logic [CNT_W-1:0]  target_r;
  logic              trace_r;
  logic              err_r;
  logic [63:0]       sum_r;
  logic [63:0]       res_r;
  logic              out_valid_r;
  logic [63:0]       out_result_r;
  logic              out_is_trace_r;
  logic              out_err_r;

  logic [IDX_W-1:0]  last_k;
  logic [IDX_W-1:0]  last_dot;
  logic [IDX_W-1:0]  a_row;
  logic [IDX_W-1:0]  b_col;
  logic              row_out;
  logic              col_out;
  logic              load_ok;

  assign in_ready = (state_r == ST_IDLE);
  assign last_k   = IDX_W'(eff_dim - 1'b1);
  assign last_dot = IDX_W'(target_r - 1'b1);
  assign row_out  = 32'(in_row) >= 32'(eff_dim);
  assign col_out  = 32'(in_col) >= 32'(eff_dim);
  assign load_ok  = (32'(in_row) < 32'(MAX_DIM)) && (32'(in_col) < 32'(MAX_DIM));

  assign wr_en   = in_valid && in_ready && (in_kind == KIND_LOAD) && load_ok;
  assign wr_addr = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);

  assign a_row     = trace_r ? i_r : row_r;
  assign b_col     = trace_r ? i_r : col_r;
  assign ctl.issue = (state_r == ST_ISSUE);
  assign ctl.first = (k_r == '0);
  assign ctl.last  = (k_r == last_k);
  assign a_addr    = ADDR_W'(a_row) * ADDR_W'(MAX_DIM) + ADDR_W'(k_r);
  assign b_addr    = ADDR_W'(k_r) * ADDR_W'(MAX_DIM) + ADDR_W'(b_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      if (dot.done) begin
        sum_r     <= sum_r + sext32(dot.value);
        dot_cnt_r <= dot_cnt_r + 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            row_r     <= IDX_W'(in_row);
            col_r     <= IDX_W'(in_col);
            trace_r   <= (in_kind == KIND_TRACE);
            sum_r     <= '0;
            dot_cnt_r <= '0;
            k_r       <= '0;
            i_r       <= '0;
            err_r     <= 1'b0;
            case (in_kind)
              KIND_PRODUCT: begin
                target_r <= CNT_W'(1);
                if (row_out || col_out) begin
                  res_r   <= '0;
                  err_r   <= 1'b1;
                  state_r <= ST_DONE;
                end else begin
                  state_r <= ST_ISSUE;
                end
              end
              KIND_TRACE: begin
                target_r <= eff_dim;
                if (eff_dim == '0) begin
                  res_r   <= '0;
                  state_r <= ST_DONE;
                end else begin
                  state_r <= ST_ISSUE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_ISSUE: begin
          if (k_r == last_k) begin
            k_r <= '0;
            if (trace_r && (i_r != last_k)) begin
              i_r <= i_r + 1'b1;
            end else begin
              state_r <= ST_WAIT;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_WAIT: begin
          if (dot.done && (dot_cnt_r == last_dot)) begin
            res_r   <= sum_r + sext32(dot.value);
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_result_r   <= res_r;
            out_is_trace_r <= trace_r;
            out_err_r      <= err_r;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_is_trace    = out_is_trace_r;
  assign out_index_error = out_err_r;

endmodule
